/* src/tpmbr_pkg.sv */
// Shared types, constants and codes for the three-pool budget reserver.
// No dependencies; imported by every module of the block.
package tpmbr_pkg;

   localparam int BYTE_BITS = 48;
   localparam int CNT_BITS  = 17;
   localparam int LC_BITS   = 8;
   localparam int PF_BITS   = 16;
   localparam int WK_BITS   = 8;
   localparam int OP_BITS   = 2;
   localparam int STS_BITS  = 3;
   localparam int CSR_BITS  = 3;

   localparam logic [OP_BITS-1:0] OP_AUTO    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_MANUAL  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd2;

   localparam logic [STS_BITS-1:0] STS_OK           = 3'd0;
   localparam logic [STS_BITS-1:0] STS_ZERO_BATCH   = 3'd1;
   localparam logic [STS_BITS-1:0] STS_ZERO_WORKERS = 3'd2;
   localparam logic [STS_BITS-1:0] STS_ZERO_HOST    = 3'd3;
   localparam logic [STS_BITS-1:0] STS_ZERO_DEV     = 3'd4;
   localparam logic [STS_BITS-1:0] STS_HOST_SHORT   = 3'd5;
   localparam logic [STS_BITS-1:0] STS_DEV_SHORT    = 3'd6;
   localparam logic [STS_BITS-1:0] STS_OVERFLOW     = 3'd7;

   localparam logic [CSR_BITS-1:0] CSR_CACHE_CAP = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_HOST_CAP  = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_DEV_CAP   = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_LOADERS   = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_MAX_HOST  = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_MAX_DEV   = 3'd5;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_RELEASE,
      CMD_CACHE_DIV,
      CMD_HOST_DIV,
      CMD_HMIN_MUL,
      CMD_HPF_DIV,
      CMD_HB_MUL,
      CMD_DEV_DIV,
      CMD_DMIN_MUL,
      CMD_DPF_DIV,
      CMD_DB_MUL,
      CMD_COMMIT,
      CMD_PUBLISH
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic         unit_start;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0]  op;
      logic                use_dev;
      logic [STS_BITS-1:0] status;
      logic                step_done;
      logic                rsp_full;
   } dp_stat_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_ISSUE,
      FSM_WAIT,
      FSM_COMMIT,
      FSM_DONE
   } fsm_state_type;

endpackage

/* src/three_pool_memory_budget_reserver_core.sv */
// Top level of the three-pool budget reserver: controller plus datapath.
// Depends on tpmbr_pkg, tpmbr_ctrl and tpmbr_dp.
//
// Keeps reserved byte totals for the decoded cache, host staging and device
// staging pools and answers each request with one result. One request is in
// work at a time; a new one is taken while the previous result still waits.
// The work is done by a restoring divider and a shift-add multiplier: an
// automatic reserve runs more unit steps than a manual one, and more again
// with device staging, while a release or a failed check uses neither unit.
// Configuration writes are always taken and must be made while idle.
module three_pool_memory_budget_reserver_core
   import tpmbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_BITS-1:0]   req_op,
   input  logic [BYTE_BITS-1:0] req_batch_size,
   input  logic [WK_BITS-1:0]   req_workers,
   input  logic                 req_use_device,
   input  logic [BYTE_BITS-1:0] req_cache_amount,
   input  logic [PF_BITS-1:0]   req_host_prefetch_req,
   input  logic [PF_BITS-1:0]   req_device_prefetch_req,
   input  logic [BYTE_BITS-1:0] req_host_release,
   input  logic [BYTE_BITS-1:0] req_device_release,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STS_BITS-1:0]  rsp_status,
   output logic [BYTE_BITS-1:0] rsp_granted_cache,
   output logic [PF_BITS-1:0]   rsp_host_prefetch,
   output logic [PF_BITS-1:0]   rsp_device_prefetch,
   output logic [BYTE_BITS-1:0] rsp_host_bytes,
   output logic [BYTE_BITS-1:0] rsp_device_bytes,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [BYTE_BITS-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   tpmbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpmbr_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_op                  (req_op),
      .req_batch_size          (req_batch_size),
      .req_workers             (req_workers),
      .req_use_device          (req_use_device),
      .req_cache_amount        (req_cache_amount),
      .req_host_prefetch_req   (req_host_prefetch_req),
      .req_device_prefetch_req (req_device_prefetch_req),
      .req_host_release        (req_host_release),
      .req_device_release      (req_device_release),
      .csr_valid               (csr_valid),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .rsp_ready               (rsp_ready),
      .rsp_valid               (rsp_valid),
      .rsp_status              (rsp_status),
      .rsp_granted_cache       (rsp_granted_cache),
      .rsp_host_prefetch       (rsp_host_prefetch),
      .rsp_device_prefetch     (rsp_device_prefetch),
      .rsp_host_bytes          (rsp_host_bytes),
      .rsp_device_bytes        (rsp_device_bytes)
   );

endmodule

/* src/tpmbr_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on tpmbr_pkg.
module tpmbr_div
   import tpmbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [BYTE_BITS-1:0] dividend,
   input  logic [BYTE_BITS-1:0] divisor,
   output logic [BYTE_BITS-1:0] quotient,
   output logic                 done
);

   localparam int CW = $clog2(BYTE_BITS);

   logic [BYTE_BITS-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [BYTE_BITS:0]   rem_shift, diff;
   logic                 ge;

   assign rem_shift = {rem_ff, quo_ff[BYTE_BITS-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};
   assign ge        = ~diff[BYTE_BITS];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(BYTE_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[BYTE_BITS-2:0], ge};
         rem_in = ge ? diff[BYTE_BITS-1:0] : rem_shift[BYTE_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* src/tpmbr_mul.sv */
// Shift-add multiplier, batch count times byte size, one count bit per cycle.
// Depends on tpmbr_pkg.
module tpmbr_mul
   import tpmbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CNT_BITS-1:0]  count,
   input  logic [BYTE_BITS-1:0] mcand,
   output logic [BYTE_BITS-1:0] product,
   output logic                 overflow,
   output logic                 done
);

   localparam int PW = BYTE_BITS + CNT_BITS;
   localparam int CW = $clog2(CNT_BITS);

   logic [PW-1:0]        acc_ff, acc_in;
   logic [CNT_BITS-1:0]  cnt_sh_ff, cnt_sh_in;
   logic [BYTE_BITS-1:0] mc_ff, mc_in;
   logic [CW-1:0]        iter_ff, iter_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      cnt_sh_in = cnt_sh_ff;
      mc_in     = mc_ff;
      iter_in   = iter_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         cnt_sh_in = count;
         mc_in     = mcand;
         iter_in   = CW'(CNT_BITS - 1);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PW-2:0], 1'b0}
                  + (cnt_sh_ff[CNT_BITS-1] ? {{CNT_BITS{1'b0}}, mc_ff} : '0);
         cnt_sh_in = {cnt_sh_ff[CNT_BITS-2:0], 1'b0};
         iter_in   = iter_ff - 1'b1;
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      cnt_sh_ff <= cnt_sh_in;
      mc_ff     <= mc_in;
      iter_ff   <= iter_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product  = acc_ff[BYTE_BITS-1:0];
   assign overflow = |acc_ff[PW-1:BYTE_BITS];
   assign done     = done_ff;

endmodule

/* src/tpmbr_dp.sv */
// Datapath: configuration, pool totals, request latch, working grant and
// result register. Depends on tpmbr_pkg, tpmbr_div and tpmbr_mul.
module tpmbr_dp
   import tpmbr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [OP_BITS-1:0]   req_op,
   input  logic [BYTE_BITS-1:0] req_batch_size,
   input  logic [WK_BITS-1:0]   req_workers,
   input  logic                 req_use_device,
   input  logic [BYTE_BITS-1:0] req_cache_amount,
   input  logic [PF_BITS-1:0]   req_host_prefetch_req,
   input  logic [PF_BITS-1:0]   req_device_prefetch_req,
   input  logic [BYTE_BITS-1:0] req_host_release,
   input  logic [BYTE_BITS-1:0] req_device_release,
   input  logic                 csr_valid,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [BYTE_BITS-1:0] csr_wdata,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [STS_BITS-1:0]  rsp_status,
   output logic [BYTE_BITS-1:0] rsp_granted_cache,
   output logic [PF_BITS-1:0]   rsp_host_prefetch,
   output logic [PF_BITS-1:0]   rsp_device_prefetch,
   output logic [BYTE_BITS-1:0] rsp_host_bytes,
   output logic [BYTE_BITS-1:0] rsp_device_bytes
);

   function automatic logic [BYTE_BITS-1:0] left_of(input logic [BYTE_BITS-1:0] cap,
                                                    input logic [BYTE_BITS-1:0] used);
      return (used >= cap) ? '0 : cap - used;
   endfunction

   function automatic logic [BYTE_BITS-1:0] min_b(input logic [BYTE_BITS-1:0] a,
                                                  input logic [BYTE_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [BYTE_BITS-1:0] sat_sub(input logic [BYTE_BITS-1:0] a,
                                                    input logic [BYTE_BITS-1:0] b);
      return (b > a) ? '0 : a - b;
   endfunction

   function automatic logic [BYTE_BITS-1:0] sat_add(input logic [BYTE_BITS-1:0] a,
                                                    input logic [BYTE_BITS-1:0] b);
      logic [BYTE_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BYTE_BITS] ? '1 : s[BYTE_BITS-1:0];
   endfunction

   function automatic logic [PF_BITS-1:0] clamp_pf(input logic [BYTE_BITS-1:0] afford,
                                                   input logic [PF_BITS-1:0]   maxb);
      logic [PF_BITS-1:0]   maxe;
      logic [BYTE_BITS-1:0] m;
      maxe = (maxb == '0) ? PF_BITS'(1) : maxb;
      m    = min_b(afford, BYTE_BITS'(maxe));
      return (m == '0) ? PF_BITS'(1) : m[PF_BITS-1:0];
   endfunction

   // configuration and pool totals
   logic [BYTE_BITS-1:0] ccap_ff, ccap_in, hcap_ff, hcap_in, dcap_ff, dcap_in;
   logic [LC_BITS-1:0]   lc_ff, lc_in;
   logic [PF_BITS-1:0]   maxh_ff, maxh_in, maxd_ff, maxd_in;
   logic [BYTE_BITS-1:0] resc_ff, resc_in, resh_ff, resh_in, resd_ff, resd_in;
   // latched request
   logic [OP_BITS-1:0]   op_ff, op_in;
   logic [BYTE_BITS-1:0] batch_ff, batch_in, amt_ff, amt_in;
   logic [BYTE_BITS-1:0] hrel_ff, hrel_in, drel_ff, drel_in;
   logic [WK_BITS-1:0]   wk_ff, wk_in;
   logic                 dev_ff, dev_in;
   // working grant
   logic [STS_BITS-1:0]  sts_ff, sts_in;
   logic [BYTE_BITS-1:0] gc_ff, gc_in, hb_ff, hb_in, db_ff, db_in, bud_ff, bud_in;
   logic [PF_BITS-1:0]   hpf_ff, hpf_in, dpf_ff, dpf_in;
   cmd_code_type         step_ff, step_in;
   logic                 done_ff;
   // result register
   logic                 rv_ff, rv_in;
   logic [STS_BITS-1:0]  rsts_ff, rsts_in;
   logic [BYTE_BITS-1:0] rgc_ff, rgc_in, rhb_ff, rhb_in, rdb_ff, rdb_in;
   logic [PF_BITS-1:0]   rhpf_ff, rhpf_in, rdpf_ff, rdpf_in;

   logic [BYTE_BITS-1:0] rem_c, rem_h, rem_d, div_a, div_b, div_q, mul_p;
   logic [LC_BITS-1:0]   lc_eff;
   logic [CNT_BITS-1:0]  mul_n;
   logic                 div_start, mul_start, div_done, mul_done, mul_ovf, is_res;
   logic                 req_manual;
   logic [STS_BITS-1:0]  pre_sts;

   assign lc_eff = (lc_ff == '0) ? LC_BITS'(1) : lc_ff;
   assign rem_c  = left_of(ccap_ff, resc_ff);
   assign rem_h  = left_of(hcap_ff, resh_ff);
   assign rem_d  = left_of(dcap_ff, resd_ff);
   assign is_res = (op_ff == OP_AUTO) || (op_ff == OP_MANUAL);
   assign req_manual = (req_op == OP_MANUAL);

   always_comb begin
      if ((req_op != OP_AUTO) && (req_op != OP_MANUAL))  pre_sts = STS_OK;
      else if (req_batch_size == '0)                     pre_sts = STS_ZERO_BATCH;
      else if (req_workers == '0)                        pre_sts = STS_ZERO_WORKERS;
      else if (req_manual && req_host_prefetch_req == '0) pre_sts = STS_ZERO_HOST;
      else if (req_manual && req_use_device && req_device_prefetch_req == '0)
         pre_sts = STS_ZERO_DEV;
      else                                               pre_sts = STS_OK;
   end

   // unit operand selection
   always_comb begin
      case (cmd.code)
         CMD_CACHE_DIV: div_a = ccap_ff;
         CMD_HOST_DIV:  div_a = hcap_ff;
         CMD_DEV_DIV:   div_a = dcap_ff;
         default:       div_a = bud_ff;
      endcase
      case (cmd.code)
         CMD_CACHE_DIV, CMD_HOST_DIV, CMD_DEV_DIV: div_b = BYTE_BITS'(lc_eff);
         default:                                  div_b = batch_ff;
      endcase
      case (cmd.code)
         CMD_HMIN_MUL: mul_n = CNT_BITS'(wk_ff) + 1'b1;
         CMD_HB_MUL:   mul_n = CNT_BITS'(hpf_ff) + CNT_BITS'(wk_ff);
         CMD_DMIN_MUL: mul_n = CNT_BITS'(2);
         default:      mul_n = CNT_BITS'(dpf_ff) + 1'b1;
      endcase
      case (cmd.code)
         CMD_CACHE_DIV, CMD_HOST_DIV, CMD_HPF_DIV, CMD_DEV_DIV, CMD_DPF_DIV:
            div_start = cmd.unit_start;
         default: div_start = 1'b0;
      endcase
      case (cmd.code)
         CMD_HMIN_MUL, CMD_HB_MUL, CMD_DMIN_MUL, CMD_DB_MUL:
            mul_start = cmd.unit_start;
         default: mul_start = 1'b0;
      endcase
   end

   tpmbr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (div_q),
      .done     (div_done)
   );

   tpmbr_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .count    (mul_n),
      .mcand    (batch_ff),
      .product  (mul_p),
      .overflow (mul_ovf),
      .done     (mul_done)
   );

   always_comb begin
      ccap_in = ccap_ff; hcap_in = hcap_ff; dcap_in = dcap_ff;
      lc_in = lc_ff; maxh_in = maxh_ff; maxd_in = maxd_ff;
      resc_in = resc_ff; resh_in = resh_ff; resd_in = resd_ff;
      op_in = op_ff; batch_in = batch_ff; amt_in = amt_ff;
      hrel_in = hrel_ff; drel_in = drel_ff; wk_in = wk_ff; dev_in = dev_ff;
      sts_in = sts_ff; gc_in = gc_ff; hb_in = hb_ff; db_in = db_ff; bud_in = bud_ff;
      hpf_in = hpf_ff; dpf_in = dpf_ff; step_in = step_ff;
      rv_in = rv_ff; rsts_in = rsts_ff; rgc_in = rgc_ff; rhb_in = rhb_ff;
      rdb_in = rdb_ff; rhpf_in = rhpf_ff; rdpf_in = rdpf_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_CACHE_CAP: ccap_in = csr_wdata;
            CSR_HOST_CAP:  hcap_in = csr_wdata;
            CSR_DEV_CAP:   dcap_in = csr_wdata;
            CSR_LOADERS:   lc_in   = csr_wdata[LC_BITS-1:0];
            CSR_MAX_HOST:  maxh_in = csr_wdata[PF_BITS-1:0];
            CSR_MAX_DEV:   maxd_in = csr_wdata[PF_BITS-1:0];
            default: ;
         endcase
      end

      if (cmd.unit_start) step_in = cmd.code;

      case (cmd.code)
         CMD_LOAD: begin
            op_in    = req_op;
            batch_in = req_batch_size;
            amt_in   = req_cache_amount;
            hrel_in  = req_host_release;
            drel_in  = req_device_release;
            wk_in    = req_workers;
            dev_in   = req_use_device;
            sts_in   = pre_sts;
            gc_in    = min_b(req_cache_amount, rem_c);
            hpf_in   = req_manual ? req_host_prefetch_req : '0;
            dpf_in   = (req_manual && req_use_device) ? req_device_prefetch_req : '0;
            hb_in    = '0;
            db_in    = '0;
         end
         CMD_RELEASE: begin
            resc_in = sat_sub(resc_ff, amt_ff);
            resh_in = sat_sub(resh_ff, hrel_ff);
            resd_in = sat_sub(resd_ff, drel_ff);
         end
         CMD_COMMIT: begin
            resc_in = sat_add(resc_ff, gc_ff);
            resh_in = sat_add(resh_ff, hb_ff);
            resd_in = sat_add(resd_ff, db_ff);
         end
         CMD_PUBLISH: begin
            rv_in   = 1'b1;
            rsts_in = sts_ff;
            if (is_res && sts_ff == STS_OK) begin
               rgc_in = gc_ff; rhpf_in = hpf_ff; rdpf_in = dpf_ff;
               rhb_in = hb_ff; rdb_in = db_ff;
            end else begin
               rgc_in = '0; rhpf_in = '0; rdpf_in = '0;
               rhb_in = '0; rdb_in = '0;
            end
         end
         default: ;
      endcase

      if (div_done || mul_done) begin
         case (step_ff)
            CMD_CACHE_DIV: gc_in  = min_b(div_q, rem_c);
            CMD_HOST_DIV:  bud_in = min_b(div_q, rem_h);
            CMD_DEV_DIV:   bud_in = min_b(div_q, rem_d);
            CMD_HPF_DIV:   hpf_in = clamp_pf(div_q - BYTE_BITS'(wk_ff), maxh_ff);
            CMD_DPF_DIV:   dpf_in = clamp_pf(div_q - BYTE_BITS'(1), maxd_ff);
            CMD_HMIN_MUL: begin
               if (mul_ovf)             sts_in = STS_OVERFLOW;
               else if (bud_ff < mul_p) sts_in = STS_HOST_SHORT;
            end
            CMD_DMIN_MUL: begin
               if (mul_ovf)             sts_in = STS_OVERFLOW;
               else if (bud_ff < mul_p) sts_in = STS_DEV_SHORT;
            end
            CMD_HB_MUL: begin
               if (mul_ovf)            sts_in = STS_OVERFLOW;
               else if (mul_p > rem_h) sts_in = STS_HOST_SHORT;
               else                    hb_in  = mul_p;
            end
            CMD_DB_MUL: begin
               if (mul_ovf)            sts_in = STS_OVERFLOW;
               else if (mul_p > rem_d) sts_in = STS_DEV_SHORT;
               else                    db_in  = mul_p;
            end
            default: ;
         endcase
      end

      if (rv_ff && rsp_ready) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      op_in_regs: begin
         op_ff <= op_in; batch_ff <= batch_in; amt_ff <= amt_in;
         hrel_ff <= hrel_in; drel_ff <= drel_in; wk_ff <= wk_in; dev_ff <= dev_in;
         gc_ff <= gc_in; hb_ff <= hb_in; db_ff <= db_in; bud_ff <= bud_in;
         hpf_ff <= hpf_in; dpf_ff <= dpf_in; step_ff <= step_in;
         rsts_ff <= rsts_in; rgc_ff <= rgc_in; rhb_ff <= rhb_in; rdb_ff <= rdb_in;
         rhpf_ff <= rhpf_in; rdpf_ff <= rdpf_in;
      end
      if (reset) begin
         ccap_ff <= '0; hcap_ff <= '0; dcap_ff <= '0;
         lc_ff <= LC_BITS'(1); maxh_ff <= PF_BITS'(1); maxd_ff <= PF_BITS'(1);
         resc_ff <= '0; resh_ff <= '0; resd_ff <= '0;
         sts_ff <= STS_OK;
         done_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         ccap_ff <= ccap_in; hcap_ff <= hcap_in; dcap_ff <= dcap_in;
         lc_ff <= lc_in; maxh_ff <= maxh_in; maxd_ff <= maxd_in;
         resc_ff <= resc_in; resh_ff <= resh_in; resd_ff <= resd_in;
         sts_ff <= sts_in;
         done_ff <= div_done | mul_done;
         rv_ff <= rv_in;
      end
   end

   assign stat.op        = op_ff;
   assign stat.use_dev   = dev_ff;
   assign stat.status    = sts_ff;
   assign stat.step_done = done_ff;
   assign stat.rsp_full  = rv_ff;

   assign rsp_valid           = rv_ff;
   assign rsp_status          = rsts_ff;
   assign rsp_granted_cache   = rgc_ff;
   assign rsp_host_prefetch   = rhpf_ff;
   assign rsp_device_prefetch = rdpf_ff;
   assign rsp_host_bytes      = rhb_ff;
   assign rsp_device_bytes    = rdb_ff;

endmodule

/* src/tpmbr_ctrl.sv */
// Controller: sequences load, release, divide and multiply steps, commit and result.
// Depends on tpmbr_pkg.
module tpmbr_ctrl
   import tpmbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   fsm_state_type state_ff, state_in;
   cmd_code_type  step_ff, step_in, step_next;
   logic          is_auto;

   assign is_auto = (stat.op == OP_AUTO);

   always_comb begin
      case (step_ff)
         CMD_CACHE_DIV: step_next = CMD_HOST_DIV;
         CMD_HOST_DIV:  step_next = CMD_HMIN_MUL;
         CMD_HMIN_MUL:  step_next = CMD_HPF_DIV;
         CMD_HPF_DIV:   step_next = CMD_HB_MUL;
         CMD_HB_MUL: begin
            if (!stat.use_dev) step_next = CMD_COMMIT;
            else if (is_auto)  step_next = CMD_DEV_DIV;
            else               step_next = CMD_DB_MUL;
         end
         CMD_DEV_DIV:   step_next = CMD_DMIN_MUL;
         CMD_DMIN_MUL:  step_next = CMD_DPF_DIV;
         CMD_DPF_DIV:   step_next = CMD_DB_MUL;
         default:       step_next = CMD_COMMIT;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      req_ready      = 1'b0;
      cmd.code       = CMD_NONE;
      cmd.unit_start = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.code = CMD_LOAD;
               state_in = FSM_DECODE;
            end
         end
         FSM_DECODE: begin
            if (stat.op == OP_RELEASE) begin
               cmd.code = CMD_RELEASE;
               state_in = FSM_DONE;
            end else if (stat.op != OP_AUTO && stat.op != OP_MANUAL) begin
               state_in = FSM_DONE;
            end else if (stat.status != STS_OK) begin
               state_in = FSM_DONE;
            end else begin
               step_in  = is_auto ? CMD_CACHE_DIV : CMD_HB_MUL;
               state_in = FSM_ISSUE;
            end
         end
         FSM_ISSUE: begin
            cmd.code       = step_ff;
            cmd.unit_start = 1'b1;
            state_in       = FSM_WAIT;
         end
         FSM_WAIT: begin
            if (stat.step_done) begin
               if (stat.status != STS_OK) begin
                  state_in = FSM_DONE;
               end else if (step_next == CMD_COMMIT) begin
                  state_in = FSM_COMMIT;
               end else begin
                  step_in  = step_next;
                  state_in = FSM_ISSUE;
               end
            end
         end
         FSM_COMMIT: begin
            cmd.code = CMD_COMMIT;
            state_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (!stat.rsp_full) begin
               cmd.code = CMD_PUBLISH;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         step_ff  <= CMD_NONE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* src/tpmbr_checker.sv */
// Port-level checks for the budget reserver, bound to the top level.
// Depends on tpmbr_pkg and three_pool_memory_budget_reserver_core.
module tpmbr_checker
   import tpmbr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STS_BITS-1:0]  rsp_status,
   input logic [BYTE_BITS-1:0] rsp_granted_cache,
   input logic [PF_BITS-1:0]   rsp_host_prefetch,
   input logic [PF_BITS-1:0]   rsp_device_prefetch,
   input logic [BYTE_BITS-1:0] rsp_host_bytes,
   input logic [BYTE_BITS-1:0] rsp_device_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |->
         rsp_granted_cache == '0 && rsp_host_bytes == '0 && rsp_device_bytes == '0
         && rsp_host_prefetch == '0 && rsp_device_prefetch == '0)
      else $error("failed request carries a grant");

   a_dev_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_device_prefetch == '0 |-> rsp_device_bytes == '0)
      else $error("device bytes without device batches");

   a_host_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_OK && rsp_host_prefetch != '0
         |-> rsp_host_bytes != '0)
      else $error("host batches granted without host bytes");

   a_req_once: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

endmodule

bind three_pool_memory_budget_reserver_core tpmbr_checker u_tpmbr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_granted_cache   (rsp_granted_cache),
   .rsp_host_prefetch   (rsp_host_prefetch),
   .rsp_device_prefetch (rsp_device_prefetch),
   .rsp_host_bytes      (rsp_host_bytes),
   .rsp_device_bytes    (rsp_device_bytes)
);

/* verif/three_pool_memory_budget_reserver_core_tb.sv */
// Self-checking testbench for three_pool_memory_budget_reserver_core.
// Depends on tpmbr_pkg; predicts every grant and status internally and
// checks results in order under random idling, stalls and several settings.
`timescale 1ns / 1ps
module three_pool_memory_budget_reserver_core_tb;
   import tpmbr_pkg::*;

   typedef bit [63:0] u64_type;
   localparam u64_type M48 = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [BYTE_BITS-1:0] ALL48 = '1;
   localparam int LIMIT = 3000000;

   typedef struct {
      logic [OP_BITS-1:0]   op;
      logic [BYTE_BITS-1:0] batch;
      logic [WK_BITS-1:0]   workers;
      logic                 dev;
      logic [BYTE_BITS-1:0] cache_amt;
      logic [PF_BITS-1:0]   hreq;
      logic [PF_BITS-1:0]   dreq;
      logic [BYTE_BITS-1:0] hrel;
      logic [BYTE_BITS-1:0] drel;
   } budget_req_type;

   typedef struct {
      logic [STS_BITS-1:0]  status;
      logic [BYTE_BITS-1:0] gcache;
      logic [PF_BITS-1:0]   hpf;
      logic [PF_BITS-1:0]   dpf;
      logic [BYTE_BITS-1:0] hbytes;
      logic [BYTE_BITS-1:0] dbytes;
   } grant_type;

   logic                 clock, reset;
   logic                 req_valid, req_ready;
   logic [OP_BITS-1:0]   req_op;
   logic [BYTE_BITS-1:0] req_batch_size;
   logic [WK_BITS-1:0]   req_workers;
   logic                 req_use_device;
   logic [BYTE_BITS-1:0] req_cache_amount;
   logic [PF_BITS-1:0]   req_host_prefetch_req;
   logic [PF_BITS-1:0]   req_device_prefetch_req;
   logic [BYTE_BITS-1:0] req_host_release;
   logic [BYTE_BITS-1:0] req_device_release;
   logic                 rsp_valid, rsp_ready;
   logic [STS_BITS-1:0]  rsp_status;
   logic [BYTE_BITS-1:0] rsp_granted_cache;
   logic [PF_BITS-1:0]   rsp_host_prefetch;
   logic [PF_BITS-1:0]   rsp_device_prefetch;
   logic [BYTE_BITS-1:0] rsp_host_bytes;
   logic [BYTE_BITS-1:0] rsp_device_bytes;
   logic                 csr_valid, csr_ready;
   logic [CSR_BITS-1:0]  csr_index;
   logic [BYTE_BITS-1:0] csr_wdata;

   three_pool_memory_budget_reserver_core uut (.*);

   // predictor copy of configuration and pool totals
   u64_type cap_cache = 0, cap_host = 0, cap_dev = 0;
   u64_type loaders = 1, max_hpf = 1, max_dpf = 1;
   u64_type used_cache = 0, used_host = 0, used_dev = 0;

   budget_req_type pending_reqs[$];
   grant_type      expected_grants[$];
   int             fails = 0;
   int             cycles = 0;
   bit             req_took = 0;
   bit             quiet = 0;
   bit             long_hold_pending = 0;
   int             req_gap = 0;
   int             rsp_hold = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic u64_type pool_left(u64_type cap, u64_type used);
      return used >= cap ? 0 : cap - used;
   endfunction

   function automatic u64_type min_u(u64_type a, u64_type b);
      return a < b ? a : b;
   endfunction

   function automatic bit product_fits(u64_type count, u64_type batch,
                                       output u64_type prod);
      prod = 0;
      if (count != 0 && batch > M48 / count) return 0;
      prod = count * batch;
      return 1;
   endfunction

   function automatic logic [2:0] size_batches(u64_type budget, u64_type batch,
                                               u64_type extra, u64_type maxb,
                                               logic [2:0] short_code,
                                               output u64_type res);
      u64_type minb, afford;
      res = 0;
      if (maxb == 0) maxb = 1;
      if (!product_fits(extra + 1, batch, minb)) return STS_OVERFLOW;
      if (budget < minb) return short_code;
      afford = min_u(budget / batch - extra, maxb);
      res = afford < 1 ? 1 : afford;
      return STS_OK;
   endfunction

   function automatic grant_type reserve_outcome(budget_req_type r);
      u64_type lc, remc, remh, remd, batch, wk;
      u64_type gc = 0, hpf = 0, dpf = 0, hb = 0, db = 0;
      logic [2:0] st = STS_OK;
      grant_type g;
      g = '{default: 0};
      lc = loaders == 0 ? 1 : loaders;
      batch = u64_type'(r.batch);
      wk = u64_type'(r.workers);
      if (r.op == OP_RELEASE) begin
         used_cache = r.cache_amt > used_cache ? 0 : used_cache - r.cache_amt;
         used_host = r.hrel > used_host ? 0 : used_host - r.hrel;
         used_dev = r.drel > used_dev ? 0 : used_dev - r.drel;
         return g;
      end
      if (r.op != OP_AUTO && r.op != OP_MANUAL) return g;
      if (r.batch == 0) st = STS_ZERO_BATCH;
      else if (r.workers == 0) st = STS_ZERO_WORKERS;
      else if (r.op == OP_MANUAL && r.hreq == 0) st = STS_ZERO_HOST;
      else if (r.op == OP_MANUAL && r.dev && r.dreq == 0) st = STS_ZERO_DEV;
      if (st == STS_OK) begin
         remc = pool_left(cap_cache, used_cache);
         remh = pool_left(cap_host, used_host);
         if (r.op == OP_AUTO) begin
            gc = min_u(cap_cache / lc, remc);
            st = size_batches(min_u(cap_host / lc, remh), batch, wk,
                              max_hpf, STS_HOST_SHORT, hpf);
         end else begin
            gc = min_u(u64_type'(r.cache_amt), remc);
            hpf = u64_type'(r.hreq);
         end
         if (st == STS_OK) begin
            if (!product_fits(hpf + wk, batch, hb)) st = STS_OVERFLOW;
            else if (hb > remh) st = STS_HOST_SHORT;
         end
         if (st == STS_OK && r.dev) begin
            remd = pool_left(cap_dev, used_dev);
            if (r.op == OP_AUTO)
               st = size_batches(min_u(cap_dev / lc, remd), batch, 1,
                                 max_dpf, STS_DEV_SHORT, dpf);
            else
               dpf = u64_type'(r.dreq);
            if (st == STS_OK) begin
               if (!product_fits(dpf + 1, batch, db)) st = STS_OVERFLOW;
               else if (db > remd) st = STS_DEV_SHORT;
            end
         end
      end
      if (st != STS_OK) begin
         g.status = st;
         return g;
      end
      used_cache = min_u(used_cache + gc, M48);
      used_host = min_u(used_host + hb, M48);
      used_dev = min_u(used_dev + db, M48);
      g.gcache = gc[47:0];
      g.hpf = hpf[15:0];
      g.dpf = dpf[15:0];
      g.hbytes = hb[47:0];
      g.dbytes = db[47:0];
      return g;
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0] >> $urandom_range(0, 47);
   endfunction

   function automatic logic [47:0] full48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   function automatic budget_req_type random_req();
      budget_req_type r;
      int k;
      k = $urandom_range(0, 99);
      r.op = k < 40 ? OP_AUTO : k < 75 ? OP_MANUAL : k < 95 ? OP_RELEASE : 2'd3;
      k = $urandom_range(0, 99);
      r.batch = k < 4 ? 48'd0 : k < 90 ? 48'($urandom_range(1, 1 << $urandom_range(0, 24)))
                                       : full48();
      k = $urandom_range(0, 99);
      r.workers = k < 4 ? 8'd0 : k < 92 ? 8'($urandom_range(1, 8)) : 8'($urandom);
      r.dev = 1'($urandom_range(0, 1));
      r.cache_amt = rand48();
      k = $urandom_range(0, 99);
      r.hreq = k < 4 ? 16'd0 : k < 90 ? 16'($urandom_range(1, 64)) : 16'($urandom);
      k = $urandom_range(0, 99);
      r.dreq = k < 4 ? 16'd0 : k < 90 ? 16'($urandom_range(1, 64)) : 16'($urandom);
      r.hrel = $urandom_range(0, 3) == 0 ? full48() : rand48();
      r.drel = $urandom_range(0, 3) == 0 ? full48() : rand48();
      if ($urandom_range(0, 19) == 0) begin
         r.batch = full48();
         r.workers = 8'($urandom);
         r.hreq = 16'($urandom);
         r.dreq = 16'($urandom);
         r.cache_amt = full48();
      end
      return r;
   endfunction

   function automatic budget_req_type make_req(logic [1:0] op, logic [47:0] batch,
                                               logic [7:0] wk, logic dev,
                                               logic [47:0] camt, logic [15:0] hq,
                                               logic [15:0] dq, logic [47:0] hr,
                                               logic [47:0] dr);
      budget_req_type r;
      r.op = op; r.batch = batch; r.workers = wk; r.dev = dev; r.cache_amt = camt;
      r.hreq = hq; r.dreq = dq; r.hrel = hr; r.drel = dr;
      return r;
   endfunction

   task automatic write_reg(logic [CSR_BITS-1:0] idx, logic [47:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CACHE_CAP: cap_cache = u64_type'(val);
         CSR_HOST_CAP:  cap_host = u64_type'(val);
         CSR_DEV_CAP:   cap_dev = u64_type'(val);
         CSR_LOADERS:   loaders = u64_type'(val[7:0]);
         CSR_MAX_HOST:  max_hpf = u64_type'(val[15:0]);
         CSR_MAX_DEV:   max_dpf = u64_type'(val[15:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic configure(logic [47:0] cc, logic [47:0] hc, logic [47:0] dc,
                            logic [7:0] lc, logic [15:0] mh, logic [15:0] md);
      write_reg(CSR_CACHE_CAP, cc);
      write_reg(CSR_HOST_CAP, hc);
      write_reg(CSR_DEV_CAP, dc);
      write_reg(CSR_LOADERS, {40'd0, lc});
      write_reg(CSR_MAX_HOST, {32'd0, mh});
      write_reg(CSR_MAX_DEV, {32'd0, md});
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_grants.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic queue_random(int n);
      repeat (n) pending_reqs.push_back(random_req());
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 0;
         end else if (pending_reqs.size() != 0) begin
            budget_req_type r;
            r = pending_reqs.pop_front();
            req_valid <= 1;
            req_op <= r.op;
            req_batch_size <= r.batch;
            req_workers <= r.workers;
            req_use_device <= r.dev;
            req_cache_amount <= r.cache_amt;
            req_host_prefetch_req <= r.hreq;
            req_device_prefetch_req <= r.dreq;
            req_host_release <= r.hrel;
            req_device_release <= r.drel;
            if (!quiet && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 8);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response ready, with bursts and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (long_hold_pending && rsp_valid) begin
         long_hold_pending <= 0;
         rsp_hold <= 400;
         rsp_ready <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_hold <= $urandom_range(0, 7);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      budget_req_type r;
      grant_type e;
      cycles <= cycles + 1;
      req_took = req_valid && req_ready && !reset;
      if (req_took) begin
         r = make_req(req_op, req_batch_size, req_workers, req_use_device,
                      req_cache_amount, req_host_prefetch_req,
                      req_device_prefetch_req, req_host_release, req_device_release);
         expected_grants.push_back(reserve_outcome(r));
      end
      if (rsp_valid && rsp_ready && !reset) begin
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected response status %0d", $time, rsp_status);
            fails++;
         end else begin
            e = expected_grants.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               fails++;
            end
            if (rsp_granted_cache !== e.gcache) begin
               $display("%0t: granted_cache exp %0h got %0h", $time, e.gcache,
                        rsp_granted_cache);
               fails++;
            end
            if (rsp_host_prefetch !== e.hpf) begin
               $display("%0t: host_prefetch exp %0h got %0h", $time, e.hpf,
                        rsp_host_prefetch);
               fails++;
            end
            if (rsp_device_prefetch !== e.dpf) begin
               $display("%0t: device_prefetch exp %0h got %0h", $time, e.dpf,
                        rsp_device_prefetch);
               fails++;
            end
            if (rsp_host_bytes !== e.hbytes) begin
               $display("%0t: host_bytes exp %0h got %0h", $time, e.hbytes,
                        rsp_host_bytes);
               fails++;
            end
            if (rsp_device_bytes !== e.dbytes) begin
               $display("%0t: device_bytes exp %0h got %0h", $time, e.dbytes,
                        rsp_device_bytes);
               fails++;
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_op = OP_AUTO;
      req_batch_size = 0;
      req_workers = 0;
      req_use_device = 0;
      req_cache_amount = 0;
      req_host_prefetch_req = 0;
      req_device_prefetch_req = 0;
      req_host_release = 0;
      req_device_release = 0;
      csr_valid = 0;
      csr_index = CSR_CACHE_CAP;
      csr_wdata = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // defaults after reset: empty pools
      pending_reqs.push_back(make_req(OP_AUTO, 48'd64, 8'd1, 1'b1, '0, '0, '0, '0,
                                      '0));
      pending_reqs.push_back(make_req(OP_MANUAL, 48'd1, 8'd1, 1'b0, 48'd5, 16'd1, '0,
                                      '0, '0));
      queue_random(20);
      drain();

      configure(48'd1 << 40, 48'd1 << 36, 48'd1 << 34, 8'd4, 16'd64, 16'd32);
      pending_reqs.push_back(make_req(OP_AUTO, 48'd4096, 8'd2, 1'b0, '0, '0, '0, '0,
                                      '0));
      pending_reqs.push_back(make_req(OP_AUTO, 48'd4096, 8'd2, 1'b1, '0, '0, '0, '0,
                                      '0));
      pending_reqs.push_back(make_req(OP_MANUAL, 48'd1000, 8'd3, 1'b1, 48'd12345,
                                      16'd7, 16'd5, '0, '0));
      pending_reqs.push_back(make_req(OP_MANUAL, 48'd1000, 8'd3, 1'b0, ALL48, 16'd7,
                                      16'd0, '0, '0));
      pending_reqs.push_back(make_req(OP_AUTO, 48'd0, 8'd2, 1'b1, '0, '0, '0, '0,
                                      '0));
      pending_reqs.push_back(make_req(OP_MANUAL, 48'd8, 8'd0, 1'b1, '0, 16'd1, 16'd1,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_MANUAL, 48'd8, 8'd2, 1'b1, '0, 16'd0, 16'd1,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_MANUAL, 48'd8, 8'd2, 1'b1, '0, 16'd4, 16'd0,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_AUTO, ALL48, 8'd255, 1'b1, '0, '0, '0, '0,
                                      '0));
      pending_reqs.push_back(make_req(OP_MANUAL, ALL48, 8'd255, 1'b1, ALL48, 16'hFFFF,
                                      16'hFFFF, ALL48, ALL48));
      pending_reqs.push_back(make_req(OP_AUTO, 48'd1 << 33, 8'd1, 1'b1, '0, '0, '0,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_MANUAL, 48'd1 << 30, 8'd1, 1'b1, '0, 16'd100,
                                      16'd100, '0, '0));
      pending_reqs.push_back(make_req(2'd3, ALL48, 8'hFF, 1'b1, ALL48, 16'hFFFF,
                                      16'hFFFF, ALL48, ALL48));
      pending_reqs.push_back(make_req(OP_RELEASE, '0, '0, 1'b0, 48'd10, 16'd20, '0,
                                      48'd20, 48'd30));
      pending_reqs.push_back(make_req(OP_RELEASE, ALL48, 8'hFF, 1'b1, ALL48, 16'hFFFF,
                                      16'hFFFF, ALL48, ALL48));
      long_hold_pending = 1;
      queue_random(140);
      drain();

      configure(ALL48, ALL48, ALL48, 8'd1, 16'hFFFF, 16'hFFFF);
      queue_random(120);
      drain();

      configure(48'd1 << 30, 48'd1 << 32, 48'd1 << 31, 8'd255, 16'd1, 16'd1);
      queue_random(100);
      drain();

      configure(full48(), 48'd1 << 38, 48'd0, 8'd0, 16'd0, 16'd0);
      queue_random(100);
      drain();

      configure(rand48(), rand48(), rand48(), 8'($urandom_range(1, 255)),
                16'($urandom), 16'($urandom));
      queue_random(100);
      drain();

      configure(48'd1 << 42, 48'd1 << 37, 48'd1 << 35, 8'd2, 16'd200, 16'd100);
      quiet = 1;
      queue_random(100);
      drain();

      repeat (500) @(posedge clock);
      if (fails == 0 && expected_grants.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
